>>> hw/rtl/ir_beacon_biphase_framer_core_defines.svh
// Assertion macros used by the checker of the beacon framer.
`ifndef IR_BEACON_BIPHASE_FRAMER_CORE_DEFINES_SVH
`define IR_BEACON_BIPHASE_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define IBF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("beacon framer check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define IBF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("beacon framer check failed");

`endif

>>> hw/rtl/ibf_pkg.sv
// Package with the types and constants of the beacon framer.
package ibf_pkg;

   // Field and register widths.
   localparam int TICK_W        = 16;
   localparam int HALF_W        = 4;
   localparam int PATTERN_W     = 8;
   localparam int PATTERN_IDX_W = 3;
   localparam int POS_W         = 4;
   localparam int SEG_W         = 2;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_BEACON_PATTERN    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_PERIOD_TICKS = 4'd1;

   // Register reset values.
   localparam logic [PATTERN_W-1:0] BEACON_PATTERN_RESET = 8'd0;
   localparam logic [TICK_W-1:0]    HALF_PERIOD_RESET    = 16'd4000;

   // Frame segment codes.
   localparam logic [SEG_W-1:0] SEG_START     = 2'd0;
   localparam logic [SEG_W-1:0] SEG_BITS      = 2'd1;
   localparam logic [SEG_W-1:0] SEG_END_LONG  = 2'd2;
   localparam logic [SEG_W-1:0] SEG_END_SHORT = 2'd3;

   // Segment lengths in half periods.
   localparam logic [HALF_W-1:0] START_HALVES     = 4'd8;
   localparam logic [HALF_W-1:0] BIT_HALVES       = 4'd2;
   localparam logic [HALF_W-1:0] END_LONG_HALVES  = 4'd4;
   localparam logic [HALF_W-1:0] END_SHORT_HALVES = 4'd1;

   // What the sequencer shows for the current transaction.
   typedef struct packed {
      logic carrier_gate;
      logic frame_begin;
   } seq_status_type;

endpackage

>>> hw/rtl/ibf_channels_if.sv
// Handshake channel interfaces of the beacon framer.
interface ibf_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

interface ibf_rsp_if;
   logic valid;
   logic ready;
   logic carrier_gate;
   logic frame_begin;

   modport source (output valid, output carrier_gate, output frame_begin, input ready);
   modport sink   (input valid, input carrier_gate, input frame_begin, output ready);
endinterface

interface ibf_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ibf_pkg::CSR_INDEX_W-1:0]    index;
   logic [ibf_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ir_beacon_biphase_framer_core.sv
// Top level of the infrared beacon biphase-mark framer.
//
// The block repeats one beacon frame forever and drives a carrier gate. Each
// request transaction carries one tick bit from a timebase; each accepted
// request produces exactly one response transaction carrying carrier_gate
// (the gate level before this tick is applied) and frame_begin (high on the
// first tick of a start burst). A request with tick low only reports the level.
// A frame is an 8 half-period start burst, FRAME_BITS biphase-mark bits sent
// least significant bit first, and an end mark of 4 plus 1 half periods.
// The csr channel writes beacon_pattern (index 0) and half_period_ticks
// (index 1); writes to other indexes are dropped. It is always ready, and is
// meant to be written only while no transaction is in flight.
// The response is registered: it is valid in the cycle after acceptance.
// The block takes one transaction per cycle while the receiver does not stall,
// with a single output register and sequencer counters that advance on each accepted tick.
// When the receiver stalls, the response register holds its transaction and
// req ready stays high only if the register is drained in the same cycle.
// Synchronous reset restores the register defaults, restarts the frame at
// the start burst with the gate high, and empties the response register.
module ir_beacon_biphase_framer_core #(
   parameter int FRAME_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   ibf_req_if.sink    req,
   ibf_rsp_if.source  rsp,
   ibf_csr_if.sink    csr
);

   logic [ibf_pkg::PATTERN_W-1:0] beacon_pattern_ff, beacon_pattern_in;
   logic [ibf_pkg::TICK_W-1:0]    half_period_ff, half_period_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic carrier_gate_ff, carrier_gate_in;
   logic frame_begin_ff, frame_begin_in;

   logic                    req_accept;
   ibf_pkg::seq_status_type seq_status;

   // The response register takes a new transaction when empty or draining.
   assign req.ready  = ~rsp_valid_ff | rsp.ready;
   assign req_accept = req.valid & req.ready;
   assign csr.ready  = 1'b1;

   // Configuration decode.
   always_comb begin
      beacon_pattern_in = beacon_pattern_ff;
      half_period_in    = half_period_ff;
      if (csr.valid) begin
         unique case (csr.index)
            ibf_pkg::REG_BEACON_PATTERN:
               beacon_pattern_in = csr.data[ibf_pkg::PATTERN_W-1:0];
            ibf_pkg::REG_HALF_PERIOD_TICKS:
               half_period_in = csr.data[ibf_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ibf_frame_seq #(
      .FRAME_BITS(FRAME_BITS)
   ) u_frame_seq (
      .clock             (clock),
      .reset             (reset),
      .step              (req_accept),
      .tick              (req.tick),
      .beacon_pattern    (beacon_pattern_ff),
      .half_period_ticks (half_period_ff),
      .status            (seq_status)
   );

   // Response register.
   assign rsp_valid_in    = req_accept | (rsp_valid_ff & ~rsp.ready);
   assign carrier_gate_in = req_accept ? seq_status.carrier_gate : carrier_gate_ff;
   assign frame_begin_in  = req_accept ? seq_status.frame_begin : frame_begin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         beacon_pattern_ff <= ibf_pkg::BEACON_PATTERN_RESET;
         half_period_ff    <= ibf_pkg::HALF_PERIOD_RESET;
      end else begin
         rsp_valid_ff      <= rsp_valid_in;
         beacon_pattern_ff <= beacon_pattern_in;
         half_period_ff    <= half_period_in;
      end
   end

   always_ff @(posedge clock) begin
      carrier_gate_ff <= carrier_gate_in;
      frame_begin_ff  <= frame_begin_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.carrier_gate = carrier_gate_ff;
   assign rsp.frame_begin  = frame_begin_ff;

endmodule

>>> hw/rtl/ibf_frame_seq.sv
// Frame sequencer: half-period timer, segment state and gate level.
module ibf_frame_seq #(
   parameter int FRAME_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             tick,
   input  logic [ibf_pkg::PATTERN_W-1:0]    beacon_pattern,
   input  logic [ibf_pkg::TICK_W-1:0]       half_period_ticks,
   output ibf_pkg::seq_status_type          status
);

   localparam int BIT_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
   localparam logic [BIT_W-1:0] LAST_POS = BIT_W'(FRAME_BITS - 1);

   logic [ibf_pkg::SEG_W-1:0]  segment_ff, segment_in;
   logic [ibf_pkg::TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [ibf_pkg::HALF_W-1:0] half_count_ff, half_count_in;
   logic [BIT_W-1:0]           bit_position_ff, bit_position_in;
   logic                       line_level_ff, line_level_in;

   logic [ibf_pkg::TICK_W-1:0] limit;
   logic [ibf_pkg::TICK_W:0]   tick_sum;
   logic                       end_half;
   logic [ibf_pkg::POS_W-1:0]  pos_ext;
   logic                       pattern_bit;
   logic                       advance;

   assign advance  = step & tick;
   assign limit    = (half_period_ticks == '0) ? ibf_pkg::TICK_W'(1) : half_period_ticks;
   assign tick_sum = {1'b0, tick_count_ff} + (ibf_pkg::TICK_W + 1)'(1);
   assign end_half = (tick_sum >= {1'b0, limit});

   // Bits beyond the pattern register are sent as zeros.
   assign pos_ext     = ibf_pkg::POS_W'(bit_position_ff);
   assign pattern_bit = (pos_ext < ibf_pkg::POS_W'(ibf_pkg::PATTERN_W)) ?
                        beacon_pattern[pos_ext[ibf_pkg::PATTERN_IDX_W-1:0]] : 1'b0;

   assign status.carrier_gate = line_level_ff;
   assign status.frame_begin  = tick && (segment_ff == ibf_pkg::SEG_START) &&
                                (half_count_ff == '0) && (tick_count_ff == '0);

   always_comb begin
      segment_in      = segment_ff;
      tick_count_in   = tick_count_ff;
      half_count_in   = half_count_ff;
      bit_position_in = bit_position_ff;
      line_level_in   = line_level_ff;
      if (advance) begin
         if (end_half) begin
            tick_count_in = '0;
            half_count_in = half_count_ff + ibf_pkg::HALF_W'(1);
            unique case (segment_ff)
               ibf_pkg::SEG_BITS: begin
                  if (half_count_in == ibf_pkg::HALF_W'(1)) begin
                     if (pattern_bit) begin
                        line_level_in = ~line_level_ff;
                     end
                  end else if (half_count_in >= ibf_pkg::BIT_HALVES) begin
                     half_count_in = '0;
                     line_level_in = ~line_level_ff;
                     if (bit_position_ff == LAST_POS) begin
                        bit_position_in = '0;
                        segment_in      = ibf_pkg::SEG_END_LONG;
                     end else begin
                        bit_position_in = bit_position_ff + BIT_W'(1);
                     end
                  end
               end
               ibf_pkg::SEG_END_LONG: begin
                  if (half_count_in >= ibf_pkg::END_LONG_HALVES) begin
                     half_count_in = '0;
                     line_level_in = ~line_level_ff;
                     segment_in    = ibf_pkg::SEG_END_SHORT;
                  end
               end
               ibf_pkg::SEG_END_SHORT: begin
                  if (half_count_in >= ibf_pkg::END_SHORT_HALVES) begin
                     segment_in      = ibf_pkg::SEG_START;
                     half_count_in   = '0;
                     bit_position_in = '0;
                     line_level_in   = 1'b1;
                  end
               end
               default: begin
                  segment_in    = ibf_pkg::SEG_START;
                  line_level_in = 1'b1;
                  if (half_count_in >= ibf_pkg::START_HALVES) begin
                     half_count_in   = '0;
                     bit_position_in = '0;
                     line_level_in   = 1'b0;
                     segment_in      = ibf_pkg::SEG_BITS;
                  end
               end
            endcase
         end else begin
            tick_count_in = tick_sum[ibf_pkg::TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_ff      <= ibf_pkg::SEG_START;
         tick_count_ff   <= '0;
         half_count_ff   <= '0;
         bit_position_ff <= '0;
         line_level_ff   <= 1'b1;
      end else begin
         segment_ff      <= segment_in;
         tick_count_ff   <= tick_count_in;
         half_count_ff   <= half_count_in;
         bit_position_ff <= bit_position_in;
         line_level_ff   <= line_level_in;
      end
   end

endmodule

>>> hw/rtl/ibf_checker.sv
// Port-level checker of the beacon framer and its bind statement.
`include "ir_beacon_biphase_framer_core_defines.svh"

module ibf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_carrier_gate,
   input logic rsp_frame_begin
);

   // A stalled response keeps its transaction.
   `IBF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_carrier_gate) && $stable(rsp_frame_begin))

   // Every accepted request shows up as a response in the next cycle.
   `IBF_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid)

   // An empty response register never blocks the request side.
   `IBF_ASSERT_IMP(a_ready_when_empty, !rsp_valid, req_ready)

   // A start burst always begins with the gate on.
   `IBF_ASSERT_IMP(a_begin_gate_on, rsp_valid && rsp_frame_begin, rsp_carrier_gate)

endmodule

bind ir_beacon_biphase_framer_core ibf_checker u_ibf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_carrier_gate (rsp.carrier_gate),
   .rsp_frame_begin  (rsp.frame_begin)
);

>>> tb/ibf_gate_monitor.sv
// Self-checking monitor that predicts the beacon framer gate and scores every response.
module ibf_gate_monitor
   import ibf_pkg::*;
#(
   parameter int FRAME_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   ibf_req_if   req,
   ibf_rsp_if   rsp,
   ibf_csr_if   csr,
   output int   mismatch_count,
   output int   awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Register shadows, written whenever the write channel completes a transaction to their index.
   logic [PATTERN_W-1:0] pattern_shadow;
   logic [TICK_W-1:0]    half_ticks_shadow;

   // Framer state as the predictor sees it.
   logic [SEG_W-1:0]     seg_now;
   logic [TICK_W-1:0]    tick_cnt;
   logic [HALF_W-1:0]    half_cnt;
   logic [POS_W:0]       bit_pos;
   logic                 gate_level;

   seq_status_type       predicted_q[$];

   // Advances the framer by one request and returns what the response must show.
   task automatic advance_framer(input logic tick_in, output seq_status_type status);
      logic [TICK_W-1:0] limit;
      limit = (half_ticks_shadow == '0) ? TICK_W'(1) : half_ticks_shadow;
      status.carrier_gate = gate_level;
      status.frame_begin  = 1'b0;
      if (tick_in) begin
         status.frame_begin = (seg_now == SEG_START) && (half_cnt == '0) && (tick_cnt == '0);
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= limit) begin
            tick_cnt = '0;
            half_cnt = half_cnt + 1'b1;
            case (seg_now)
               SEG_BITS: begin
                  if (half_cnt == 4'd1) begin
                     // A one toggles again in the middle of its bit cell.
                     if ((bit_pos < PATTERN_W) && pattern_shadow[bit_pos[PATTERN_IDX_W-1:0]])
                        gate_level = ~gate_level;
                  end else if (half_cnt >= BIT_HALVES) begin
                     half_cnt   = '0;
                     bit_pos    = bit_pos + 1'b1;
                     gate_level = ~gate_level;
                     if (bit_pos >= FRAME_BITS) begin
                        bit_pos = '0;
                        seg_now = SEG_END_LONG;
                     end
                  end
               end
               SEG_END_LONG: begin
                  if (half_cnt >= END_LONG_HALVES) begin
                     half_cnt   = '0;
                     gate_level = ~gate_level;
                     seg_now    = SEG_END_SHORT;
                  end
               end
               SEG_END_SHORT: begin
                  if (half_cnt >= END_SHORT_HALVES) begin
                     seg_now    = SEG_START;
                     half_cnt   = '0;
                     bit_pos    = '0;
                     gate_level = 1'b1;
                  end
               end
               default: begin
                  seg_now    = SEG_START;
                  gate_level = 1'b1;
                  if (half_cnt >= START_HALVES) begin
                     half_cnt   = '0;
                     bit_pos    = '0;
                     gate_level = 1'b0;
                     seg_now    = SEG_BITS;
                  end
               end
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      seq_status_type predicted;
      seq_status_type observed;
      int             errors;
      errors = 0;
      if (reset) begin
         pattern_shadow    = BEACON_PATTERN_RESET;
         half_ticks_shadow = HALF_PERIOD_RESET;
         seg_now           = SEG_START;
         tick_cnt          = '0;
         half_cnt          = '0;
         bit_pos           = '0;
         gate_level        = 1'b1;
         predicted_q.delete();
         mismatch_count <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == REG_BEACON_PATTERN)
               pattern_shadow = csr.data[PATTERN_W-1:0];
            else if (csr.index == REG_HALF_PERIOD_TICKS)
               half_ticks_shadow = csr.data[TICK_W-1:0];
         end
         // Responses are scored before new requests, as every response is registered.
         if (rsp.valid && rsp.ready) begin
            observed.carrier_gate = rsp.carrier_gate;
            observed.frame_begin  = rsp.frame_begin;
            if (predicted_q.size() == 0) begin
               $display("%0t: response with no prediction waiting, actual gate %b begin %b",
                        $time, observed.carrier_gate, observed.frame_begin);
               errors++;
            end else begin
               predicted = predicted_q.pop_front();
               if (observed.carrier_gate !== predicted.carrier_gate) begin
                  $display("%0t: carrier_gate expected %b actual %b", $time,
                           predicted.carrier_gate, observed.carrier_gate);
                  errors++;
               end
               if (observed.frame_begin !== predicted.frame_begin) begin
                  $display("%0t: frame_begin expected %b actual %b", $time,
                           predicted.frame_begin, observed.frame_begin);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready) begin
            advance_framer(req.tick, predicted);
            predicted_q.push_back(predicted);
         end
         mismatch_count <= mismatch_count + errors;
      end
      awaited_count <= predicted_q.size();
   end

endmodule

>>> tb/tb.sv
// Top-level testbench of the beacon framer: clock, reset, stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ibf_pkg::*;

   localparam int FRAME_BITS      = 8;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int TICK_ONE_PCT    = 85;

   // Register indexes that map to nothing; writes to them must leave the block unchanged.
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_LOW = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_TOP = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Percentages that shape the handshake traffic of the current phase.
   int idle_pct  = 0;
   int stall_pct = 0;

   int mismatch_count;
   int awaited_count;

   ibf_req_if tick_req();
   ibf_rsp_if gate_rsp();
   ibf_csr_if cfg_wr();

   ir_beacon_biphase_framer_core #(
      .FRAME_BITS(FRAME_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (tick_req),
      .rsp  (gate_rsp),
      .csr  (cfg_wr)
   );

   // The monitor sees all three channels, keeps its own model of the framer and
   // counts every mismatch; this module only drives traffic and reports the outcome.
   ibf_gate_monitor #(
      .FRAME_BITS(FRAME_BITS)
   ) u_gate_monitor (
      .clock         (clock),
      .reset         (reset),
      .req           (tick_req),
      .rsp           (gate_rsp),
      .csr           (cfg_wr),
      .mismatch_count(mismatch_count),
      .awaited_count (awaited_count)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random each cycle; a phase with a zero stall rate
   // keeps ready high throughout.
   always @(posedge clock) begin
      gate_rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Presents one tick transaction and holds it until the block accepts it.
   // Random idle cycles come first, so gaps land between any two transactions.
   // Valid stays high from one transaction to the next when no gap is drawn.
   task automatic send_tick(input logic tick_val);
      while ($urandom_range(99) < idle_pct) begin
         tick_req.valid <= 1'b0;
         @(posedge clock);
      end
      tick_req.valid <= 1'b1;
      tick_req.tick  <= tick_val;
      do @(posedge clock); while (!tick_req.ready);
   endtask

   // Closes a burst of tick transactions and waits until every response is in.
   // The first wait is unconditional, so the transaction accepted at the last
   // edge is already counted when the outstanding count is examined.
   task automatic drain_responses();
      tick_req.valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   // One register write transaction; valid drops for a cycle afterwards so that
   // back-to-back writes never lower and raise it within the same time step.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  value);
      cfg_wr.valid <= 1'b1;
      cfg_wr.index <= idx;
      cfg_wr.data  <= value;
      do @(posedge clock); while (!cfg_wr.ready);
      cfg_wr.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      tick_req.valid <= 1'b0;
      tick_req.tick  <= 1'b0;
      cfg_wr.valid   <= 1'b0;
      cfg_wr.index   <= '0;
      cfg_wr.data    <= '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, all with steady traffic.
      // Reset defaults: a hold first must show the gate high without a frame
      // start; the first real tick must flag the start burst.
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      drain_responses();

      // Writes to unmapped indexes must be dropped: the framer keeps counting
      // toward the default half period of 4000 ticks.
      write_reg(REG_UNMAPPED_TOP, 16'hFFFF);
      write_reg(REG_UNMAPPED_LOW, 16'h0001);
      send_tick(1'b1);
      send_tick(1'b1);
      drain_responses();

      // Shrinking the half period below the ticks already counted ends the half
      // period on the very next tick. The pattern write carries ones above bit 7,
      // which the block has to discard, and sets an all-ones code.
      write_reg(REG_HALF_PERIOD_TICKS, 16'd1);
      write_reg(REG_BEACON_PATTERN, 16'hFFFF);
      repeat (8) send_tick(1'b1);
      drain_responses();

      // A zero half period behaves as one tick; the pattern goes to all zeros.
      write_reg(REG_HALF_PERIOD_TICKS, 16'd0);
      write_reg(REG_BEACON_PATTERN, 16'h0000);
      repeat (6) send_tick(1'b1);
      drain_responses();

      // Largest half period, then a cut back to two ticks in the middle of it.
      write_reg(REG_HALF_PERIOD_TICKS, 16'hFFFF);
      repeat (3) send_tick(1'b1);
      drain_responses();
      write_reg(REG_HALF_PERIOD_TICKS, 16'd2);
      repeat (2) send_tick(1'b1);
      drain_responses();

      // Random part. Mostly real ticks with short half periods, so that whole
      // frames run many times over; holds are mixed in throughout. Each phase
      // takes a fresh pattern and half period and its own traffic shape.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_reg(REG_BEACON_PATTERN, CSR_DATA_W'($urandom_range(16'hFFFF)));
         if (phase % 4 == 3)
            write_reg(REG_HALF_PERIOD_TICKS, CSR_DATA_W'($urandom_range(4, 9)));
         else
            write_reg(REG_HALF_PERIOD_TICKS, CSR_DATA_W'($urandom_range(0, 3)));
         case (phase % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 67;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 67;
            end
            default: begin
               idle_pct  = 34;
               stall_pct = 34;
            end
         endcase
         repeat (ITEMS_PER_PHASE) send_tick($urandom_range(99) < TICK_ONE_PCT);
         drain_responses();
      end

      // Everything has been answered; let the pipeline run quiet so that a
      // stray extra response would still be caught before the verdict.
      idle_pct  = 0;
      stall_pct = 0;
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS ir_beacon_biphase_framer_core");
      end else begin
         $display("FAIL ir_beacon_biphase_framer_core");
      end
      $finish;
   end

   // Watchdog: fails the run if the stimulus has not finished within its time limit.
   initial begin
      #2_000_000;
      $display("FAIL ir_beacon_biphase_framer_core");
      $finish;
   end

endmodule

>>> ir_beacon_biphase_framer_core.f
+incdir+hw/rtl
hw/rtl/ibf_pkg.sv
hw/rtl/ibf_channels_if.sv
hw/rtl/ibf_frame_seq.sv
hw/rtl/ir_beacon_biphase_framer_core.sv
hw/rtl/ibf_checker.sv
tb/ibf_gate_monitor.sv
tb/tb.sv
